// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the core module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define KVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define KVT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/kvt_pkg.sv
// ----------------------------------------------------------------------------
// Key/value table package
// Field widths, action and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int KEY_W       = 8;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 7;
    localparam int RESULT_LIMIT = 64;

    // Requested operation of an input transaction.
    typedef enum logic [1:0] {
        ACT_SET    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_GET    = 2'd2,
        ACT_DUMP   = 2'd3
    } kvt_action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } kvt_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        latch_in;
        logic        idx_clear;
        logic        idx_inc;
        logic        rd_en;
        logic        rd_next;
        logic        wr_en;
        logic        wr_at_count;
        logic        wr_from_rd;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        load_out;
        kvt_status_t res_status;
        logic        val_from_mem;
        logic        key_from_mem;
        logic        last;
    } kvt_cmd_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic idx_at_count;
        logic idx_next_at_count;
        logic key_match;
        logic dump_last;
        logic count_zero;
        logic count_full;
        logic out_free;
    } kvt_sts_t;

endpackage

// File: design/kvt_if.sv
// ----------------------------------------------------------------------------
// Key/value table channels
// Valid/ready interfaces for the request and result channels.
// ----------------------------------------------------------------------------

// Request channel: one transaction per table operation.
interface kvt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  key;
    logic [31:0] new_value;

    modport source (output valid, output action, output key, output new_value,
                    input ready);
    modport sink (input valid, input action, input key, input new_value,
                  output ready);
endinterface

// Result channel: one or more transactions per request.
interface kvt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] value;
    logic [7:0]  entry_key;
    logic        last;
    logic [6:0]  count;

    modport source (output valid, output status, output value, output entry_key,
                    output last, output count, input ready);
    modport sink (input valid, input status, input value, input entry_key,
                  input last, input count, output ready);
endinterface

// File: design/kvt_datapath.sv
// ----------------------------------------------------------------------------
// Key/value table datapath
// Entry memory, scan index, entry count, request latch and result register.
// ----------------------------------------------------------------------------
module kvt_datapath #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_key,
    input  logic [31:0]      in_new_value,
    input  kvt_pkg::kvt_cmd_t cmd,
    output kvt_pkg::kvt_sts_t sts,
    kvt_out_if.source        out_ch
);

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W = kvt_pkg::KEY_W + kvt_pkg::VALUE_W;

    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [kvt_pkg::KEY_W-1:0]   key_reg;
    logic [kvt_pkg::VALUE_W-1:0] nval_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W:0]              idx_plus;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic                          out_valid_reg;
    kvt_pkg::kvt_status_t          out_status_reg;
    logic [kvt_pkg::VALUE_W-1:0]   out_value_reg;
    logic [kvt_pkg::KEY_W-1:0]     out_key_reg;
    logic                          out_last_reg;
    logic [kvt_pkg::COUNT_W-1:0]   out_count_reg;

    // Address and data selection for the entry memory.
    assign idx_plus = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign rd_addr  = cmd.rd_next ? idx_plus[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_addr  = cmd.wr_at_count ? count_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_data  = cmd.wr_from_rd ? rd_data_reg : {key_reg, nval_reg};

    // Entry memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Request latch.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            key_reg  <= in_key;
            nval_reg <= in_new_value;
        end
    end

    // Scan index and entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus[CNT_W-1:0];
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - {{(CNT_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // Result register: holds one transaction until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.res_status;
            out_value_reg  <= cmd.val_from_mem ? rd_data_reg[kvt_pkg::VALUE_W-1:0]
                                               : '0;
            out_key_reg    <= cmd.key_from_mem ? rd_data_reg[ENTRY_W-1:kvt_pkg::VALUE_W]
                                               : key_reg;
            out_last_reg   <= cmd.last;
            out_count_reg  <= kvt_pkg::COUNT_W'(count_reg);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.status    = out_status_reg;
    assign out_ch.value     = out_value_reg;
    assign out_ch.entry_key = out_key_reg;
    assign out_ch.last      = out_last_reg;
    assign out_ch.count     = out_count_reg;

    // Status flags for the controller.
    always_comb
    begin
        sts.idx_at_count      = (idx_reg == count_reg);
        sts.idx_next_at_count = (idx_plus == {1'b0, count_reg});
        sts.key_match         = (rd_data_reg[ENTRY_W-1:kvt_pkg::VALUE_W] == key_reg);
        sts.dump_last         = (idx_plus == {1'b0, count_reg}) ||
                                (32'(idx_reg) == kvt_pkg::RESULT_LIMIT - 1);
        sts.count_zero        = (count_reg == '0);
        sts.count_full        = (count_reg == CNT_W'(MAX_ENTRIES));
        sts.out_free          = !out_valid_reg || out_ch.ready;
    end

endmodule

// File: design/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// Key/value table controller
// Sequences search, append, shift-down compaction and dump over the datapath.
// ----------------------------------------------------------------------------
module kvt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_action,
    output logic              in_ready,
    input  kvt_pkg::kvt_sts_t sts,
    output kvt_pkg::kvt_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SREAD,
        S_SCMP,
        S_SHREAD,
        S_SHWRITE,
        S_DREAD,
        S_DWAIT,
        S_DEMIT,
        S_EMIT
    } state_t;

    state_t               state_reg;
    kvt_pkg::kvt_action_t action_reg;
    kvt_pkg::kvt_status_t res_status_reg;
    logic                 res_mem_reg;

    // State and held result fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            action_reg     <= kvt_pkg::ACT_SET;
            res_status_reg <= kvt_pkg::ST_OK;
            res_mem_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        action_reg <= kvt_pkg::kvt_action_t'(in_action);
                        if (kvt_pkg::kvt_action_t'(in_action) != kvt_pkg::ACT_DUMP)
                        begin
                            state_reg <= S_SREAD;
                        end
                        else if (sts.count_zero)
                        begin
                            res_status_reg <= kvt_pkg::ST_EMPTY;
                            res_mem_reg    <= 1'b0;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_DREAD;
                        end
                    end
                end
                S_SREAD:
                begin
                    if (sts.idx_at_count)
                    begin
                        // Key not present.
                        res_mem_reg <= 1'b0;
                        if (action_reg == kvt_pkg::ACT_SET)
                        begin
                            res_status_reg <= sts.count_full ? kvt_pkg::ST_FULL
                                                             : kvt_pkg::ST_OK;
                        end
                        else
                        begin
                            res_status_reg <= kvt_pkg::ST_NOT_FOUND;
                        end
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SCMP;
                    end
                end
                S_SCMP:
                begin
                    if (sts.key_match)
                    begin
                        res_status_reg <= kvt_pkg::ST_OK;
                        res_mem_reg    <= (action_reg == kvt_pkg::ACT_GET);
                        state_reg      <= (action_reg == kvt_pkg::ACT_REMOVE) ? S_SHREAD
                                                                              : S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SREAD;
                    end
                end
                S_SHREAD:
                begin
                    state_reg <= sts.idx_next_at_count ? S_EMIT : S_SHWRITE;
                end
                S_SHWRITE:
                begin
                    state_reg <= S_SHREAD;
                end
                S_DREAD:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    state_reg <= S_DEMIT;
                end
                S_DEMIT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= sts.dump_last ? S_IDLE : S_DREAD;
                    end
                end
                S_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath commands decoded from the state.
    always_comb
    begin
        cmd            = '0;
        cmd.res_status = kvt_pkg::ST_OK;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in  = 1'b1;
                    cmd.idx_clear = 1'b1;
                end
            end
            S_SREAD:
            begin
                if (!sts.idx_at_count)
                begin
                    cmd.rd_en = 1'b1;
                end
                else if (action_reg == kvt_pkg::ACT_SET && !sts.count_full)
                begin
                    // Append the new entry at the end of the table.
                    cmd.wr_en       = 1'b1;
                    cmd.wr_at_count = 1'b1;
                    cmd.cnt_inc     = 1'b1;
                end
            end
            S_SCMP:
            begin
                if (!sts.key_match)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else if (action_reg == kvt_pkg::ACT_SET)
                begin
                    // Overwrite the value of the matching entry.
                    cmd.wr_en = 1'b1;
                end
            end
            S_SHREAD:
            begin
                if (sts.idx_next_at_count)
                begin
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                end
            end
            S_SHWRITE:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_from_rd = 1'b1;
                cmd.idx_inc    = 1'b1;
            end
            S_DREAD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_DWAIT:
            begin
                cmd.rd_en = 1'b0;
            end
            S_DEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out     = 1'b1;
                    cmd.res_status   = kvt_pkg::ST_OK;
                    cmd.val_from_mem = 1'b1;
                    cmd.key_from_mem = 1'b1;
                    cmd.last         = sts.dump_last;
                    cmd.idx_inc      = !sts.dump_last;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out     = 1'b1;
                    cmd.res_status   = res_status_reg;
                    cmd.val_from_mem = res_mem_reg;
                    cmd.last         = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: design/key_value_table_core.sv
// ----------------------------------------------------------------------------
// Key/value table core
// Insertion-ordered table of byte keys with 32-bit values.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (action, key, new_value) and results leave on
// out_ch (status, value, entry_key, last, count); both are valid/ready.
// One request is worked at a time; in_ch.ready is high only while the block
// waits for a request. Set, get and remove scan the entries in order through
// an entry memory with one write port and registered read data, reading and
// then comparing each entry checked. Remove then moves every later entry
// down by one place, reading and then writing each entry moved. A dump reads
// each entry, waits for its data and emits one result per entry, up to
// RESULT_LIMIT, the final one with last set; an empty table gives one result.
// The result register frees the request side: the next request is taken
// while the final result of the previous one still waits on out_ch.
// When the receiver stalls, the block holds before loading the next result.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_value_table_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    kvt_in_if.sink    in_ch,
    kvt_out_if.source out_ch
);

    kvt_pkg::kvt_cmd_t cmd;
    kvt_pkg::kvt_sts_t sts;

    // Sequencer.
    kvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Storage and result path.
    kvt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_key       (in_ch.key),
        .in_new_value (in_ch.new_value),
        .cmd          (cmd),
        .sts          (sts),
        .out_ch       (out_ch)
    );

    // Checks on the sequencing.
    `KVT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
    `KVT_ASSERT_IMP(a_no_append_when_full, clk, rst_n, cmd.cnt_inc, !sts.count_full)
    `KVT_ASSERT_IMP(a_no_remove_when_empty, clk, rst_n, cmd.cnt_dec, !sts.count_zero)
    `KVT_ASSERT_IMP(a_load_only_when_free, clk, rst_n, cmd.load_out, sts.out_free && !in_ch.ready)
    `KVT_ASSERT_IMP(a_empty_is_final, clk, rst_n, out_ch.valid && out_ch.status == kvt_pkg::ST_EMPTY, out_ch.last && out_ch.count == '0)

endmodule
